// ===== rtl/srtf_pkg.sv =====
package srtf_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int TIME_BITS_DEF     = 16;

   localparam int FUNC_W   = 1;
   localparam int ID_W     = 6;
   localparam int LEN_W    = 16;
   localparam int STATUS_W = 3;
   localparam int WIDE_W   = 32;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_IDLE   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RAN    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DONE   = 3'd4;

   // saturate a wide time value to the response field width
   function automatic logic [LEN_W-1:0] clip_len(input logic [WIDE_W-1:0] value);
      logic [LEN_W-1:0] result;
      if (|value[WIDE_W-1:LEN_W]) begin
         result = '1;
      end else begin
         result = value[LEN_W-1:0];
      end
      return result;
   endfunction

endpackage

// ===== rtl/srtf_ram.sv =====
module srtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/shortest_remaining_time_scheduler_core.sv =====
// shortest-remaining-time-first scheduler core
// request channel (req_valid/req_ready): req_func selects a job arrival or one time tick;
//   an arrival carries req_job_id and req_burst_length and lands in the lowest free slot,
//   stamped with the current time; a full table answers with a reject status
// response channel (rsp_valid/rsp_ready): exactly one response per request, carrying
//   rsp_status, rsp_run_id and, for a finished job, turnaround and waiting times
// an arrival passes ST_FINAL before it responds; a tick walks every slot of the job table
//   memory, one read per cycle, then passes ST_DRAIN, ST_UPDATE and ST_FINAL before it
//   responds; req_ready is high only in ST_IDLE, so no new request is taken until the
//   current one has placed its response in the output register
// the minimum search runs over the single read port of the table memory; valid bits
//   live in flops, so no clearing pass is needed after reset
// reset (synchronous, active high) empties the table, zeroes time and drops any response
// a stalled response sits in the output register; the core can take one more request and
//   holds its result in ST_FINAL, with req_ready low, until the output register is free
module shortest_remaining_time_scheduler_core #(
   parameter int TABLE_ENTRIES = srtf_pkg::TABLE_ENTRIES_DEF,
   parameter int TIME_BITS     = srtf_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [srtf_pkg::FUNC_W-1:0]   req_func,
   input  logic [srtf_pkg::ID_W-1:0]     req_job_id,
   input  logic [srtf_pkg::LEN_W-1:0]    req_burst_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srtf_pkg::STATUS_W-1:0] rsp_status,
   output logic [srtf_pkg::ID_W-1:0]     rsp_run_id,
   output logic [srtf_pkg::LEN_W-1:0]    rsp_turnaround_time,
   output logic [srtf_pkg::LEN_W-1:0]    rsp_waiting_time
);

   import srtf_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int WORD_W = ID_W + LEN_W + TIME_BITS + LEN_W;

   // one table memory word per slot
   typedef struct packed {
      logic [ID_W-1:0]      job;
      logic [LEN_W-1:0]     burst;
      logic [TIME_BITS-1:0] arrival;
      logic [LEN_W-1:0]     remaining;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_FINAL
   } state_type;

   state_type                state_ff;
   logic [TABLE_ENTRIES-1:0] slot_valid_ff;
   logic [TIME_BITS-1:0]     time_ff;
   logic [IDX_W-1:0]         scan_idx_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic                     rd_vld_ff;
   logic                     best_vld_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   slot_type                 best_ff;
   logic [STATUS_W-1:0]      res_status_ff;
   logic [ID_W-1:0]          res_id_ff;
   logic [WIDE_W-1:0]        tat_ff;
   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [ID_W-1:0]          rsp_run_id_ff;
   logic [LEN_W-1:0]         rsp_tat_ff;
   logic [LEN_W-1:0]         rsp_wt_ff;

   logic                     req_fire;
   logic                     free_found;
   logic [IDX_W-1:0]         free_idx;
   logic [TIME_BITS-1:0]     time_in;
   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   slot_type                 ram_wr_word;
   logic                     ram_rd_en;
   logic [WORD_W-1:0]        ram_rd_data;
   slot_type                 rd_word;
   logic                     cand_take;
   logic                     best_done;
   logic [WIDE_W-1:0]        burst_wide;
   logic [WIDE_W-1:0]        wt_wide;
   logic                     out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lowest free slot for an arrival
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // time saturates at its maximum
   assign time_in = (time_ff == '1) ? time_ff : time_ff + TIME_BITS'(1);

   // candidate compare: remaining, then arrival, then id; ties keep the lower slot
   assign rd_word   = slot_type'(ram_rd_data);
   assign cand_take = rd_vld_ff && slot_valid_ff[rd_idx_ff] &&
                      (!best_vld_ff ||
                       ({rd_word.remaining, rd_word.arrival, rd_word.job} <
                        {best_ff.remaining, best_ff.arrival, best_ff.job}));

   assign best_done = (best_ff.remaining <= LEN_W'(1));

   // table write port: arrivals store a new slot, ticks write back the remaining time
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = best_idx_ff;
      ram_wr_word = best_ff;
      ram_wr_word.remaining = best_ff.remaining - LEN_W'(1);
      if (req_fire && (req_func == FUNC_ARRIVE)) begin
         ram_wr_en   = free_found;
         ram_wr_addr = free_idx;
         ram_wr_word.job       = req_job_id;
         ram_wr_word.burst     = req_burst_length;
         ram_wr_word.arrival   = time_ff;
         ram_wr_word.remaining = req_burst_length;
      end else if (state_ff == ST_UPDATE) begin
         ram_wr_en = best_vld_ff && !best_done;
      end
   end

   assign ram_rd_en = (state_ff == ST_SCAN);

   srtf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   // waiting time from the registered turnaround
   assign burst_wide = WIDE_W'(best_ff.burst);
   assign wt_wide    = (tat_ff >= burst_wide) ? tat_ff - burst_wide : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         time_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         best_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= 1'b0;
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // running minimum over the slot stream
         if (cand_take) begin
            best_vld_ff <= 1'b1;
            best_idx_ff <= rd_idx_ff;
            best_ff     <= rd_word;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_func == FUNC_ARRIVE) begin
                     res_id_ff <= '0;
                     tat_ff    <= '0;
                     if (free_found) begin
                        slot_valid_ff[free_idx] <= 1'b1;
                        res_status_ff           <= STATUS_ACCEPT;
                     end else begin
                        res_status_ff <= STATUS_FULL;
                     end
                     state_ff <= ST_FINAL;
                  end else begin
                     scan_idx_ff <= '0;
                     best_vld_ff <= 1'b0;
                     state_ff    <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               rd_vld_ff   <= 1'b1;
               rd_idx_ff   <= scan_idx_ff;
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
               if (scan_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               time_ff <= time_in;
               tat_ff  <= '0;
               if (!best_vld_ff) begin
                  res_status_ff <= STATUS_IDLE;
                  res_id_ff     <= '0;
               end else begin
                  res_id_ff <= best_ff.job;
                  if (best_done) begin
                     slot_valid_ff[best_idx_ff] <= 1'b0;
                     res_status_ff              <= STATUS_DONE;
                     tat_ff <= WIDE_W'(time_in - best_ff.arrival);
                  end else begin
                     res_status_ff <= STATUS_RAN;
                  end
               end
               state_ff <= ST_FINAL;
            end
            ST_FINAL: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_run_id_ff <= res_id_ff;
                  rsp_tat_ff    <= clip_len(tat_ff);
                  rsp_wt_ff     <= clip_len(wt_wide);
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_run_id          = rsp_run_id_ff;
   assign rsp_turnaround_time = rsp_tat_ff;
   assign rsp_waiting_time    = rsp_wt_ff;

`ifndef SYNTHESIS
   // the chosen slot must still be occupied when it is updated
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) && best_vld_ff |-> slot_valid_ff[best_idx_ff])
      else $error("picked slot is not occupied");

   // an arrival into a table with room fills exactly one slot
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_func == FUNC_ARRIVE) && !(&slot_valid_ff) |=>
      ($countones(slot_valid_ff) == $past($countones(slot_valid_ff)) + 1))
      else $error("arrival did not fill one slot");

   // time moves only on the update step of a tick
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPDATE) |=> (time_ff == $past(time_ff)))
      else $error("time changed outside a tick update");
`endif

endmodule

// ===== tb/tb_shortest_remaining_time_scheduler_core.sv =====
module tb_shortest_remaining_time_scheduler_core;
   import srtf_pkg::*;

   // table size and time width as built
   localparam int SLOTS        = TABLE_ENTRIES_DEF;
   localparam int TB_TIME_BITS = TIME_BITS_DEF;
   localparam int TIME_TOP     = (1 << TB_TIME_BITS) - 1;
   // bursts above this many ticks count as long jobs that may clog the table
   localparam int LONG_BURST   = 255;
   // settle time covers two ticks after the last response
   localparam int SETTLE_CYCLES = 2 * (SLOTS + 4);
   localparam int RANDOM_ITEMS  = 1300;
   localparam int DRAIN_EVERY   = 300;

   // one response as the scheduler reports it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     run_id;
      logic [LEN_W-1:0]    turnaround;
      logic [LEN_W-1:0]    waiting;
   } sched_rsp_type;

   // how a random segment mixes arrivals and ticks
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   // job table model plus the responses it still owes
   class sched_scoreboard;
      bit               slot_used[SLOTS];
      logic [ID_W-1:0]  slot_id[SLOTS];
      int unsigned      slot_left[SLOTS];
      int unsigned      slot_stamp[SLOTS];
      int unsigned      slot_len[SLOTS];
      int unsigned      now;
      sched_rsp_type    owed_rsp[$];
      int               failures;

      function new();
         now = 0;
         failures = 0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
      endfunction

      // slot a runs ahead of slot b: less left, then earlier stamp, then lower id
      function bit runs_ahead(int a, int b);
         if (slot_left[a] != slot_left[b]) return slot_left[a] < slot_left[b];
         if (slot_stamp[a] != slot_stamp[b]) return slot_stamp[a] < slot_stamp[b];
         return slot_id[a] < slot_id[b];
      endfunction

      function int occupied();
         int n;
         n = 0;
         foreach (slot_used[i]) if (slot_used[i]) n++;
         return n;
      endfunction

      function int long_jobs();
         int n;
         n = 0;
         foreach (slot_used[i]) if (slot_used[i] && slot_left[i] > LONG_BURST) n++;
         return n;
      endfunction

      // schedule one accepted request and queue the response it must produce
      function void note_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                 logic [LEN_W-1:0] burst);
         sched_rsp_type r;
         int            pick;
         int unsigned   tat;
         int unsigned   wt;
         r = '0;
         pick = -1;
         if (func == FUNC_ARRIVE) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!slot_used[i]) begin
                  pick = i;
                  break;
               end
            end
            if (pick < 0) begin
               r.status = STATUS_FULL;
            end else begin
               slot_used[pick]  = 1'b1;
               slot_id[pick]    = id;
               slot_left[pick]  = burst;
               slot_len[pick]   = burst;
               slot_stamp[pick] = now;
               r.status = STATUS_ACCEPT;
            end
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && (pick < 0 || runs_ahead(i, pick))) pick = i;
            end
            if (now < TIME_TOP) now++;
            if (pick < 0) begin
               r.status = STATUS_IDLE;
            end else begin
               r.run_id = slot_id[pick];
               if (slot_left[pick] <= 1) begin
                  tat = (now >= slot_stamp[pick]) ? now - slot_stamp[pick] : 0;
                  wt  = (tat >= slot_len[pick]) ? tat - slot_len[pick] : 0;
                  slot_used[pick] = 1'b0;
                  r.status     = STATUS_DONE;
                  r.turnaround = (tat > 65535) ? '1 : LEN_W'(tat);
                  r.waiting    = (wt > 65535) ? '1 : LEN_W'(wt);
               end else begin
                  slot_left[pick]--;
                  r.status = STATUS_RAN;
               end
            end
         end
         owed_rsp = {owed_rsp, r};
      endfunction

      function void check_response(sched_rsp_type got);
         sched_rsp_type want;
         if (owed_rsp.size() == 0) begin
            $display("%0t: response with none expected, actual status %0d run_id %0d",
                     $time, got.status, got.run_id);
            failures++;
            return;
         end
         want = owed_rsp.pop_front();
         if (got.status != want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            failures++;
         end
         if (got.run_id != want.run_id) begin
            $display("%0t: run_id mismatch, expected %0d, actual %0d",
                     $time, want.run_id, got.run_id);
            failures++;
         end
         if (got.turnaround != want.turnaround) begin
            $display("%0t: turnaround_time mismatch, expected %0d, actual %0d",
                     $time, want.turnaround, got.turnaround);
            failures++;
         end
         if (got.waiting != want.waiting) begin
            $display("%0t: waiting_time mismatch, expected %0d, actual %0d",
                     $time, want.waiting, got.waiting);
            failures++;
         end
      endfunction
   endclass

   // block inputs, all known from time zero
   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic [FUNC_W-1:0]   req_func         = FUNC_ARRIVE;
   logic [ID_W-1:0]     req_job_id       = '0;
   logic [LEN_W-1:0]    req_burst_length = '0;
   logic                rsp_ready        = 1'b0;

   // block outputs
   logic                req_ready;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_run_id;
   logic [LEN_W-1:0]    rsp_turnaround_time;
   logic [LEN_W-1:0]    rsp_waiting_time;

   // stretches where a side never idles
   bit quiet_sender   = 1'b0;
   bit quiet_receiver = 1'b0;

   sched_scoreboard board = new();

   shortest_remaining_time_scheduler_core #(
      .TABLE_ENTRIES(SLOTS),
      .TIME_BITS    (TB_TIME_BITS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_job_id         (req_job_id),
      .req_burst_length   (req_burst_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_run_id         (rsp_run_id),
      .rsp_turnaround_time(rsp_turnaround_time),
      .rsp_waiting_time   (rsp_waiting_time)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // present one request after a random gap and hold it until taken
   // called at a rising edge; valid stays high straight into the next request on a zero gap
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                               input logic [LEN_W-1:0] burst);
      int unsigned gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_job_id       <= id;
      req_burst_length <= burst;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(func, id, burst);
   endtask

   task automatic arrive(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] burst);
      send_request(FUNC_ARRIVE, id, burst);
   endtask

   // id and burst are don't-care on a tick, so they carry noise
   task automatic tick();
      send_request(FUNC_TICK, ID_W'($urandom), LEN_W'($urandom));
   endtask

   // arrival shaped by the table contents: mostly short jobs so that jobs finish,
   // at most one long job at a time, and full-range noise into a full table
   task automatic random_arrival();
      logic [ID_W-1:0]  id;
      logic [LEN_W-1:0] burst;
      int unsigned      roll;
      id   = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(36, 63))
                                         : ID_W'($urandom_range(0, 35));
      roll = $urandom_range(0, 99);
      if (board.occupied() == SLOTS) begin
         burst = LEN_W'($urandom);
      end else if (roll < 75) begin
         burst = LEN_W'($urandom_range(0, 6));
      end else if (roll < 95 || board.long_jobs() != 0) begin
         burst = LEN_W'($urandom_range(0, 40));
      end else begin
         burst = LEN_W'($urandom_range(LONG_BURST + 1, 700));
      end
      arrive(id, burst);
   endtask

   // hold off new requests until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.owed_rsp.size() != 0);
   endtask

   // response side: random back-pressure per response, checked on every handshake
   initial begin
      int unsigned   stall;
      sched_rsp_type got;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) quiet_receiver = !quiet_receiver;
         stall = quiet_receiver ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.status     = rsp_status;
         got.run_id     = rsp_run_id;
         got.turnaround = rsp_turnaround_time;
         got.waiting    = rsp_waiting_time;
         board.check_response(got);
      end
   end

   // request side: directed opening, random segments, long-job tail
   initial begin
      int      sent;
      int      next_drain;
      int      seg_len;
      int      tick_share;
      mix_type mix;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table gives an idle tick that still moves time
      tick();
      // zero burst finishes on its first tick
      arrive(ID_W'(0), LEN_W'(0));
      tick();
      // id above the id range, equal bursts and stamps, then a duplicate id
      arrive(ID_W'(63), LEN_W'(3));
      arrive(ID_W'(5), LEN_W'(3));
      arrive(ID_W'(5), LEN_W'(3));
      arrive(ID_W'(35), LEN_W'(1));
      // fill the rest of the table
      for (int k = 0; k < 12; k++) begin
         arrive(ID_W'($urandom_range(0, 35)), LEN_W'($urandom_range(2, 9)));
      end
      // full table rejects, widest burst and id as well
      arrive(ID_W'(63), '1);
      repeat (5) tick();
      wait_drained();

      sent       = 0;
      next_drain = DRAIN_EVERY;
      while (sent < RANDOM_ITEMS) begin
         seg_len      = $urandom_range(10, 60);
         mix          = mix_type'($urandom_range(0, 2));
         quiet_sender = ($urandom_range(0, 3) == 0);
         unique case (mix)
            MIX_FILL:  tick_share = 15;
            MIX_DRAIN: tick_share = 85;
            default:   tick_share = 50;
         endcase
         for (int k = 0; k < seg_len; k++) begin
            if ($urandom_range(0, 99) < tick_share) begin
               tick();
            end else begin
               random_arrival();
            end
         end
         sent += seg_len;
         if (sent >= next_drain) begin
            wait_drained();
            next_drain += DRAIN_EVERY;
         end
      end

      // widest accepted burst, run a few ticks against it
      quiet_sender = 1'b0;
      wait_drained();
      arrive(ID_W'(1), '1);
      repeat (3) tick();
      req_valid <= 1'b0;

      // let owed responses land, then watch for strays
      while (board.owed_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

endmodule
